>>> hw/rtl/tilt_pkg.sv
`timescale 1ns / 1ps

package tilt_pkg;

  // Widths of the sample and angle words.
  localparam int DATA_W = 16;

  // Default depth of the angle pipeline; the table below covers up to 24.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN = 24;

  // Square root: one result bit per cell over a 64-bit radicand.
  localparam int SQ_STEPS = 32;
  localparam int SUM_W    = 32;
  localparam int ROOT_W   = 32;
  localparam int REM_W    = 34;

  // Rotation datapath widths (vector components and angle accumulator).
  localparam int XW = 35;
  localparam int AW = 34;

  // A quarter turn in units of pi/2^31.
  localparam logic signed [AW-1:0] ACC_QTR = AW'(64'sd1073741824);

  // atan(2^-i) in units of pi/2^31, rounded.
  localparam logic signed [AW-1:0] ATAN_TAB [ATAN_LEN] = '{
    AW'(536870912), AW'(316933406), AW'(167458907), AW'(85004756),
    AW'(42667331),  AW'(21354465),  AW'(10679838),  AW'(5340245),
    AW'(2670163),   AW'(1335087),   AW'(667544),    AW'(333772),
    AW'(166886),    AW'(83443),     AW'(41722),     AW'(20861),
    AW'(10430),     AW'(5215),      AW'(2608),      AW'(1304),
    AW'(652),       AW'(326),       AW'(163),       AW'(81)
  };

  // State handed from one square-root cell to the next.
  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_st_t;

  // State handed from one rotation cell to the next.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } cordic_vec_t;

  // Folds the vector into the right half plane and preloads the angle.
  function automatic cordic_vec_t tilt_pre(logic signed [XW-1:0] num,
                                           logic signed [XW-1:0] den);
    cordic_vec_t v;
    v.zero = (num == '0) && (den == '0);
    if (den < 0) begin
      if (num >= 0) begin
        v.x   = num;
        v.y   = -den;
        v.acc = ACC_QTR;
      end else begin
        v.x   = -num;
        v.y   = den;
        v.acc = -ACC_QTR;
      end
    end else begin
      v.x   = den;
      v.y   = num;
      v.acc = '0;
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/tilt_if.sv
`timescale 1ns / 1ps

interface tilt_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [tilt_pkg::DATA_W-1:0]  accel_x;
  logic signed [tilt_pkg::DATA_W-1:0]  accel_y;
  logic signed [tilt_pkg::DATA_W-1:0]  accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [tilt_pkg::DATA_W-1:0]  roll_angle;
  logic signed [tilt_pkg::DATA_W-1:0]  pitch_angle;
  logic        [tilt_pkg::DATA_W-1:0]  incline_angle;

  modport source (output valid, roll_angle, pitch_angle, incline_angle, input ready);
  modport sink   (input valid, roll_angle, pitch_angle, incline_angle, output ready);
endinterface

>>> hw/rtl/tilt_sqrt_cell.sv
`timescale 1ns / 1ps

module tilt_sqrt_cell (
  input  logic               clk,
  input  logic               en,
  input  tilt_pkg::sqrt_st_t st_i,
  output tilt_pkg::sqrt_st_t st_o
);
  import tilt_pkg::*;

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  sqrt_st_t         st_nxt;
  sqrt_st_t         st_r;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh     = {st_i.rem, st_i.rad[SUM_W-1 -: 2]};
    trial      = (REM_W+2)'({st_i.root, 2'b01});
    st_nxt.rad = {st_i.rad[SUM_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      st_nxt.rem  = REM_W'(rem_sh - trial);
      st_nxt.root = {st_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      st_nxt.rem  = REM_W'(rem_sh);
      st_nxt.root = {st_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign st_o = st_r;

endmodule

>>> hw/rtl/tilt_cordic_cell.sv
`timescale 1ns / 1ps

module tilt_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic                  clk,
  input  logic                  en,
  input  tilt_pkg::cordic_vec_t v_i,
  output tilt_pkg::cordic_vec_t v_o
);
  import tilt_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  cordic_vec_t          v_nxt;
  cordic_vec_t          v_r;

  // Turn toward the x axis by atan(2^-STAGE); shifts floor on negatives.
  always_comb begin
    xs         = v_i.x >>> STAGE;
    ys         = v_i.y >>> STAGE;
    v_nxt.zero = v_i.zero;
    if (v_i.y > 0) begin
      v_nxt.x   = v_i.x + ys;
      v_nxt.y   = v_i.y - xs;
      v_nxt.acc = v_i.acc + ATAN_TAB[STAGE];
    end else begin
      v_nxt.x   = v_i.x - ys;
      v_nxt.y   = v_i.y + xs;
      v_nxt.acc = v_i.acc - ATAN_TAB[STAGE];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_r <= v_nxt;
    end
  end

  assign v_o = v_r;

endmodule

>>> hw/rtl/accel_tilt_angles.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields                                        Handshake
// in_ch    in   accel_x, accel_y, accel_z (signed 16)         valid/ready
// out_ch   out  roll_angle, pitch_angle (signed 16),          valid/ready
//               incline_angle (unsigned 16)
//
// One word is accepted every cycle unless the output stalls; the latency is
// set by the 32-cell square-root chain and the rotation cell chain.
// Reset (synchronous, active low) clears only the valid bits of the pipe.
// A stall on the output freezes the whole pipe; ready follows the output
// register being empty or being taken in the same cycle.

module accel_tilt_angles #(
  parameter int CORDIC_STAGES = tilt_pkg::CORDIC_STAGES_DEF
) (
  input logic          clk,
  input logic          rst_n,
  tilt_in_if.sink      in_ch,
  tilt_out_if.source   out_ch
);
  import tilt_pkg::*;

  // Valid bit k goes with pipe stage k: squares, sums, 32 root cells, the
  // fold stage, the rotation cells, and finally the output register.
  localparam int NPIPE   = CORDIC_STAGES + SQ_STEPS + 4;
  localparam int SIDE_N  = SQ_STEPS + 2;

  logic             en;
  logic [NPIPE-1:0] vld_r;

  // Raw components travel beside the root cells, one tap per stage.
  logic signed [DATA_W-1:0] ax_r [SIDE_N];
  logic signed [DATA_W-1:0] ay_r [SIDE_N];
  logic signed [DATA_W-1:0] az_r [SIDE_N];

  logic signed [2*DATA_W-1:0] px, py, pz;
  logic [SUM_W-2:0]           sqx_r, sqy_r, sqz_r;

  // Root chains: 0 is |(y,z)|, 1 is |(x,z)|, 2 is |(x,y)|.
  sqrt_st_t    sq_st [3][SQ_STEPS+1];
  // Rotation chains: 0 roll, 1 pitch, 2 incline.
  cordic_vec_t cv    [3][CORDIC_STAGES+1];
  cordic_vec_t pre_nxt [3];
  cordic_vec_t pre_r   [3];

  logic signed [XW-1:0] num_c [3];
  logic signed [XW-1:0] den_c [3];

  logic signed [AW-1:0] rnd [3];
  logic signed [DATA_W-1:0] roll_nxt, pitch_nxt;
  logic [DATA_W-1:0]        incl_nxt;
  logic signed [DATA_W-1:0] roll_r, pitch_r;
  logic [DATA_W-1:0]        incl_r;

  // The pipe moves whenever the output register is free or being drained.
  assign en          = !vld_r[NPIPE-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NPIPE-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r[0] <= in_ch.accel_x;
      ay_r[0] <= in_ch.accel_y;
      az_r[0] <= in_ch.accel_z;
      for (int k = 1; k < SIDE_N; k++) begin
        ax_r[k] <= ax_r[k-1];
        ay_r[k] <= ay_r[k-1];
        az_r[k] <= az_r[k-1];
      end
    end
  end

  // Squares first; each fits in 31 bits since the largest is 2^30.
  assign px = in_ch.accel_x * in_ch.accel_x;
  assign py = in_ch.accel_y * in_ch.accel_y;
  assign pz = in_ch.accel_z * in_ch.accel_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= px[SUM_W-2:0];
      sqy_r <= py[SUM_W-2:0];
      sqz_r <= pz[SUM_W-2:0];
    end
  end

  // The sums of squares are registered as the root radicands. The root is
  // taken of sum * 2^32, whose low digits are all zero, so the radicand
  // register only needs the sum itself with zeros shifted in behind it.
  sqrt_st_t sum_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r[0] <= '{rad: SUM_W'(sqy_r) + SUM_W'(sqz_r), rem: '0, root: '0};
      sum_r[1] <= '{rad: SUM_W'(sqx_r) + SUM_W'(sqz_r), rem: '0, root: '0};
      sum_r[2] <= '{rad: SUM_W'(sqx_r) + SUM_W'(sqy_r), rem: '0, root: '0};
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_root
    assign sq_st[c][0] = sum_r[c];
    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_cell
      tilt_sqrt_cell u_cell (
        .clk  (clk),
        .en   (en),
        .st_i (sq_st[c][j]),
        .st_o (sq_st[c][j+1])
      );
    end
  end

  // Operands of the three angles, all scaled by 2^16. The raw components
  // are signed, so they are sign-extended into the rotation width.
  always_comb begin
    num_c[0] = XW'($signed({ax_r[SIDE_N-1], 16'h0000}));
    den_c[0] = XW'({1'b0, sq_st[0][SQ_STEPS].root});
    num_c[1] = XW'($signed({ay_r[SIDE_N-1], 16'h0000}));
    den_c[1] = XW'({1'b0, sq_st[1][SQ_STEPS].root});
    num_c[2] = XW'({1'b0, sq_st[2][SQ_STEPS].root});
    den_c[2] = XW'($signed({az_r[SIDE_N-1], 16'h0000}));
    for (int c = 0; c < 3; c++) begin
      pre_nxt[c] = tilt_pre(num_c[c], den_c[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r <= pre_nxt;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_rot
    assign cv[c][0] = pre_r[c];
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
      tilt_cordic_cell #(.STAGE(k)) u_cell (
        .clk (clk),
        .en  (en),
        .v_i (cv[c][k]),
        .v_o (cv[c][k+1])
      );
    end
  end

  // Round to nearest by adding half an output step, then saturate. A zero
  // pair of operands gives a zero angle whatever the rotations left behind.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = (cv[c][CORDIC_STAGES].acc + AW'(32768)) >>> 16;
    end
    if (cv[0][CORDIC_STAGES].zero) begin
      roll_nxt = '0;
    end else if (rnd[0] < -AW'(16384)) begin
      roll_nxt = -DATA_W'(16384);
    end else if (rnd[0] > AW'(16384)) begin
      roll_nxt = DATA_W'(16384);
    end else begin
      roll_nxt = rnd[0][DATA_W-1:0];
    end
    if (cv[1][CORDIC_STAGES].zero) begin
      pitch_nxt = '0;
    end else if (rnd[1] < -AW'(16384)) begin
      pitch_nxt = -DATA_W'(16384);
    end else if (rnd[1] > AW'(16384)) begin
      pitch_nxt = DATA_W'(16384);
    end else begin
      pitch_nxt = rnd[1][DATA_W-1:0];
    end
    if (cv[2][CORDIC_STAGES].zero || rnd[2] < 0) begin
      incl_nxt = '0;
    end else if (rnd[2] > AW'(32768)) begin
      incl_nxt = DATA_W'(32768);
    end else begin
      incl_nxt = rnd[2][DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= roll_nxt;
      pitch_r <= pitch_nxt;
      incl_r  <= incl_nxt;
    end
  end

  assign out_ch.valid         = vld_r[NPIPE-1];
  assign out_ch.roll_angle    = roll_r;
  assign out_ch.pitch_angle   = pitch_r;
  assign out_ch.incline_angle = incl_r;

  // A stalled pipe keeps every valid bit where it was.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipe valid bits moved during a stall");

  a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.roll_angle >= -16'sd16384 &&
                      out_ch.roll_angle <= 16'sd16384))
    else $error("roll angle out of range");

  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.pitch_angle >= -16'sd16384 &&
                      out_ch.pitch_angle <= 16'sd16384))
    else $error("pitch angle out of range");

  a_incl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.incline_angle <= 16'd32768))
    else $error("incline angle out of range");

  // An empty output register never holds off the input.
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NPIPE-1] |-> in_ch.ready)
    else $error("input held off with an empty output register");

endmodule

>>> bench/tb_accel_tilt_angles.sv
`timescale 1ns / 1ps

module tb_accel_tilt_angles;
  import tilt_pkg::*;

  // The block is a feed-forward pipe: a square-root chain followed by the
  // rotation chain. Its depth sets how long we wait for the last word.
  localparam int STAGES    = CORDIC_STAGES_DEF;
  localparam int PIPE_LAT  = STAGES + 36;
  localparam int N_RANDOM  = 1730;
  localparam int CYC_LIMIT = 400000;
  localparam int LONG_HOLD = 300;
  localparam int HOLD_AT   = 600;
  localparam int DRAIN_AT  = 1200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  tilt_in_if  in_if ();
  tilt_out_if out_if ();

  accel_tilt_angles dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // One set of angles, as the block should hand it out.
  typedef struct {
    logic signed [DATA_W-1:0] roll;
    logic signed [DATA_W-1:0] pitch;
    logic        [DATA_W-1:0] incl;
  } angles_t;

  // A directed row. Where the answer is obvious it is typed in; otherwise
  // the predictor supplies it.
  typedef struct {
    logic signed [DATA_W-1:0] ax;
    logic signed [DATA_W-1:0] ay;
    logic signed [DATA_W-1:0] az;
    bit                       typed;
    logic signed [DATA_W-1:0] roll;
    logic signed [DATA_W-1:0] pitch;
    logic        [DATA_W-1:0] incl;
  } tilt_row_t;

  localparam int N_ROWS = 22;
  tilt_row_t tilt_rows [N_ROWS] = '{
    // The zero vector gives zero for every angle.
    '{16'sd0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0, 16'd0},
    // Single axes, both signs, small and full scale.
    '{16'sd0, 16'sd0, 16'sd1, 1'b0, 0, 0, 0},
    '{16'sd0, 16'sd0, -16'sd1, 1'b0, 0, 0, 0},
    '{16'sd1, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
    '{-16'sd1, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
    '{16'sd0, 16'sd1, 16'sd0, 1'b0, 0, 0, 0},
    '{16'sd0, -16'sd1, 16'sd0, 1'b0, 0, 0, 0},
    '{16'sd32767, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
    '{-16'sd32768, 16'sd0, 16'sd0, 1'b0, 0, 0, 0},
    '{16'sd0, 16'sd32767, 16'sd0, 1'b0, 0, 0, 0},
    '{16'sd0, -16'sd32768, 16'sd0, 1'b0, 0, 0, 0},
    '{16'sd0, 16'sd0, 16'sd32767, 1'b0, 0, 0, 0},
    '{16'sd0, 16'sd0, -16'sd32768, 1'b0, 0, 0, 0},
    // Corners of the cube stress the widest magnitudes.
    '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 0, 0, 0},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 0, 0, 0},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 1'b0, 0, 0, 0},
    '{16'sd32767, -16'sd32768, 16'sd32767, 1'b0, 0, 0, 0},
    // A lying-flat sensor and one upside down, the usual gravity cases.
    '{16'sd12, -16'sd7, 16'sd16384, 1'b0, 0, 0, 0},
    '{-16'sd40, 16'sd25, -16'sd16384, 1'b0, 0, 0, 0},
    // Equal components (the first row on the 45 degree diagonals) and a mixed vector.
    '{16'sd1000, 16'sd1000, 16'sd0, 1'b0, 0, 0, 0},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0, 0, 0, 0},
    '{16'sd21845, -16'sd10922, 16'sd5461, 1'b0, 0, 0, 0}
  };

  angles_t angles_q[$];
  int      n_errors   = 0;
  int      n_sent     = 0;
  int      n_checked  = 0;
  int      burst_left = 0;
  int      cyc        = 0;

  // Integer square root, one result bit per pass, as the block computes it.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Length of (a, b), scaled by 2^16.
  function automatic longint vec_len(longint a, longint b);
    longint unsigned sq;
    sq = longint'(a * a) + longint'(b * b);
    return longint'(int_sqrt(sq << 32));
  endfunction

  // Vectoring rotation for atan2(num, den); result in units of pi/32768.
  // Arithmetic right shifts of longint are floor shifts, as required.
  function automatic longint rot_atan2(longint num, longint den);
    longint x, y, acc, xn;
    acc = 0;
    if (num == 0 && den == 0) return 0;
    if (den < 0) begin
      if (num >= 0) begin
        x = num; y = -den; acc = 64'sd1073741824;
      end else begin
        x = -num; y = den; acc = -64'sd1073741824;
      end
    end else begin
      x = den; y = num;
    end
    for (int i = 0; i < STAGES && i < ATAN_LEN; i++) begin
      if (y > 0) begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        acc += longint'(ATAN_TAB[i]);
      end else begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        acc -= longint'(ATAN_TAB[i]);
      end
      x = xn;
    end
    return (acc + 32768) >>> 16;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic angles_t tilt_predict(logic signed [DATA_W-1:0] ax,
                                           logic signed [DATA_W-1:0] ay,
                                           logic signed [DATA_W-1:0] az);
    angles_t a;
    longint  x, y, z;
    x = ax; y = ay; z = az;
    a.roll  = DATA_W'(clip(rot_atan2(x * 65536, vec_len(y, z)), -16384, 16384));
    a.pitch = DATA_W'(clip(rot_atan2(y * 65536, vec_len(x, z)), -16384, 16384));
    a.incl  = DATA_W'(clip(rot_atan2(vec_len(x, y), z * 65536), 0, 32768));
    return a;
  endfunction

  // Offers one word and returns once the block has taken it. Valid stays
  // high across back-to-back words; gaps come only between bursts.
  task automatic offer_word(input logic signed [DATA_W-1:0] ax,
                            input logic signed [DATA_W-1:0] ay,
                            input logic signed [DATA_W-1:0] az,
                            input bit typed, input angles_t typed_ang);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid   = 1'b1;
    in_if.accel_x = ax;
    in_if.accel_y = ay;
    in_if.accel_z = az;
    do @(posedge clk); while (!in_if.ready);
    angles_q.push_back(typed ? typed_ang : tilt_predict(ax, ay, az));
    n_sent++;
  endtask

  // Random vectors: mostly full range, with small, near-axis and sign-edge
  // words mixed in so the folding and zero paths are hit often.
  function automatic logic signed [DATA_W-1:0] rand_comp(int kind);
    case (kind)
      0:       return DATA_W'($urandom_range(0, 16'hFFFF));
      1:       return DATA_W'($signed($urandom_range(0, 128)) - 64);
      2:       return $urandom_range(0, 1) ? 16'sh7FFF : -16'sh8000;
      default: return '0;
    endcase
  endfunction

  // Receiver: a mode, picked anew at random, sets the stall pattern, and one
  // long hold lets the pipe fill and push back on the sender.
  initial begin
    int mode, hold_left, pat;
    bit held;
    mode = 0; hold_left = 0; pat = 0; held = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      pat++;
      if (pat % 64 == 0) mode = $urandom_range(0, 3);
      if (!held && n_sent >= HOLD_AT) begin
        held = 1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else begin
        case (mode)
          0:       out_if.ready = 1'b1;
          1:       out_if.ready = $urandom_range(0, 1);
          2:       out_if.ready = (pat % 4 == 0);
          default: out_if.ready = ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Compare every accepted word with the oldest prediction.
  always @(posedge clk) begin
    angles_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected word roll=%0d pitch=%0d incline=%0d", $time,
                 out_if.roll_angle, out_if.pitch_angle, out_if.incline_angle);
        n_errors++;
      end else begin
        e = angles_q.pop_front();
        n_checked++;
        if (out_if.roll_angle !== e.roll) begin
          $display("%0t: roll expected %0d got %0d", $time, e.roll, out_if.roll_angle);
          n_errors++;
        end
        if (out_if.pitch_angle !== e.pitch) begin
          $display("%0t: pitch expected %0d got %0d", $time, e.pitch,
                   out_if.pitch_angle);
          n_errors++;
        end
        if (out_if.incline_angle !== e.incl) begin
          $display("%0t: incline expected %0d got %0d", $time, e.incl,
                   out_if.incline_angle);
          n_errors++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cyc++;
    if (cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cyc, angles_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    angles_t ang;
    int      k;
    in_if.valid   = 1'b0;
    in_if.accel_x = '0;
    in_if.accel_y = '0;
    in_if.accel_z = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (tilt_rows[r]) begin
      ang.roll  = tilt_rows[r].roll;
      ang.pitch = tilt_rows[r].pitch;
      ang.incl  = tilt_rows[r].incl;
      offer_word(tilt_rows[r].ax, tilt_rows[r].ay, tilt_rows[r].az,
                 tilt_rows[r].typed, ang);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      // Once mid-run the sender stops until the pipe has fully drained.
      if (n == DRAIN_AT) begin
        @(negedge clk);
        in_if.valid = 1'b0;
        burst_left = 0;
        while (angles_q.size() != 0) @(posedge clk);
      end
      k = $urandom_range(0, 9);
      k = (k < 6) ? 0 : (k < 8) ? 1 : (k < 9) ? 2 : $urandom_range(1, 3);
      offer_word(rand_comp(k), rand_comp($urandom_range(0, 4) == 0 ? 1 : k),
                 rand_comp($urandom_range(0, 5) == 0 ? 3 : k), 1'b0, ang);
    end
    @(negedge clk);
    in_if.valid = 1'b0;

    while (angles_q.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LAT) @(posedge clk);

    $display("Sent %0d vectors (%0d directed), checked %0d angle words,", n_sent,
             N_ROWS, n_checked);
    $display("with bursty input, output stalls, one long hold and one full drain.");
    if (n_errors == 0 && angles_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
